@@ sv/sav_pkg.sv @@
package sav_pkg;

	// Store geometry; word addresses are carried on 6-bit fields
	localparam int STORE_WORDS = 64;
	localparam int PCB_WORDS   = 5;
	localparam int NAME_CHARS  = 8;
	localparam int VALUE_CHARS = 8;

	localparam int ADDR_W = 6;
	localparam int FP_W   = $clog2(STORE_WORDS + 1);
	localparam int IW_W   = 7;
	localparam int NEED_W = ((FP_W > IW_W) ? FP_W : IW_W) + 1;
	localparam int STR_W  = 64;

	typedef logic [2:0]        op_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [STR_W-1:0]  str_t;

	localparam op_t OP_ALLOC = 3'd0;
	localparam op_t OP_SET   = 3'd1;
	localparam op_t OP_GET   = 3'd2;
	localparam op_t OP_CHECK = 3'd3;
	localparam op_t OP_CLEAR = 3'd4;

	// One stored word: name and value side by side
	typedef struct packed {
		str_t name;
		str_t value;
	} entry_t;

	// Cut a packed string at its first zero byte and at max_chars characters
	function automatic str_t pack_trim(input str_t s, input int max_chars);
		str_t r;
		logic stop;
		r = '0;
		stop = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (i >= max_chars || s[8*i +: 8] == 8'h00) begin
				stop = 1'b1;
			end
			if (!stop) begin
				r[8*i +: 8] = s[8*i +: 8];
			end
		end
		return r;
	endfunction

endpackage

@@ sv/segment_allocator_variable_table_core.sv @@
// Segment allocator with a per-word variable table. One item is taken at a
// time. Allocate, check, clear and unknown operations go from the run state
// straight to the done state; the next item can be taken once the result has
// moved into the output register. Set and get scan the segment from seg_low
// upwards through the single read port of the word memory, one word per
// cycle, visiting at most seg_high - seg_low + 1 words of the 64-word store
// before the done state. A held result stalls the block until it is taken.
// Clear drops the fill pointer and every valid bit together: each word has a
// valid bit and an invalid word reads as an empty name with a zero value, so
// no clearing pass is needed after reset.
module segment_allocator_variable_table_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sav_pkg::op_t         operation,
	input  logic [6:0]           instr_words,
	input  sav_pkg::addr_t       seg_low,
	input  sav_pkg::addr_t       seg_high,
	input  sav_pkg::addr_t       probe_addr,
	input  sav_pkg::str_t        key_name,
	input  sav_pkg::str_t        new_value,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 status,
	output sav_pkg::addr_t       seg_base,
	output sav_pkg::addr_t       seg_last,
	output sav_pkg::addr_t       pcb_base,
	output sav_pkg::str_t        read_value
);
	import sav_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_SCAN = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]             state_q;
	op_t                    op_q;
	logic [IW_W-1:0]        iw_q;
	addr_t                  lo_q;
	addr_t                  hi_q;
	addr_t                  probe_q;
	str_t                   key_q;
	str_t                   val_q;
	logic [FP_W-1:0]        fp_q;
	logic [STORE_WORDS-1:0] vld_q;

	// Result waiting for the output register
	logic  res_status_q;
	addr_t res_base_q;
	addr_t res_last_q;
	addr_t res_pcb_q;
	str_t  res_value_q;

	// Output register
	logic  out_valid_q;
	logic  status_q;
	addr_t seg_base_q;
	addr_t seg_last_q;
	addr_t pcb_base_q;
	str_t  read_value_q;

	// Word memory
	entry_t mem [STORE_WORDS];
	entry_t rd_data_s1;
	addr_t  addr_s1;
	addr_t  rd_addr;
	logic   mem_we;

	logic              out_free;
	logic [NEED_W-1:0] need;
	logic [NEED_W-1:0] pcb_sum;
	logic              alloc_ok;
	logic              run_status;
	str_t              cur_name;
	logic              set_hit;
	logic              get_hit;
	logic              scan_hit;
	logic              scan_end;

	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	// Allocation sums
	assign pcb_sum  = NEED_W'(fp_q) + NEED_W'(iw_q);
	assign need     = pcb_sum + NEED_W'(PCB_WORDS);
	assign alloc_ok = (op_q == OP_ALLOC) && (need <= NEED_W'(STORE_WORDS));

	// Status of the operations that finish without a scan
	always_comb begin
		unique case (op_q)
			OP_ALLOC: run_status = !alloc_ok;
			OP_CHECK: run_status = !(probe_q >= lo_q && probe_q <= hi_q);
			OP_CLEAR: run_status = 1'b0;
			default:  run_status = 1'b1;
		endcase
	end

	// Compare the word that came back from memory
	assign cur_name = vld_q[addr_s1] ? rd_data_s1.name : '0;
	assign set_hit  = (cur_name == '0) || (cur_name == key_q);
	assign get_hit  = (cur_name == key_q);
	assign scan_hit = (op_q == OP_SET) ? set_hit : get_hit;
	assign scan_end = (addr_s1 == hi_q);

	assign mem_we  = (state_q == ST_SCAN) && (op_q == OP_SET) && set_hit;
	assign rd_addr = (state_q == ST_SCAN) ? addr_t'(addr_s1 + 1'b1) : lo_q;

	// Memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_s1] <= '{name: key_q, value: val_q};
		end
		rd_data_s1 <= mem[rd_addr];
	end

	// Capture the item
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q    <= operation;
			iw_q    <= instr_words;
			lo_q    <= seg_low;
			hi_q    <= seg_high;
			probe_q <= probe_addr;
			key_q   <= pack_trim(key_name, NAME_CHARS);
			val_q   <= pack_trim(new_value, VALUE_CHARS);
		end
	end

	// Sequencer, allocator and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fp_q    <= '0;
			vld_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if ((op_q == OP_SET || op_q == OP_GET) && lo_q <= hi_q) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_DONE;
					end
					if (alloc_ok) begin
						fp_q <= FP_W'(need);
					end
					if (op_q == OP_CLEAR) begin
						fp_q  <= '0;
						vld_q <= '0;
					end
				end
				ST_SCAN: begin
					if (scan_hit || scan_end) begin
						state_q <= ST_DONE;
					end
					if (mem_we) begin
						vld_q[addr_s1] <= 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Scan address and result
	always_ff @(posedge clk) begin
		if (state_q == ST_RUN) begin
			addr_s1      <= lo_q;
			res_status_q <= run_status;
			res_base_q   <= alloc_ok ? addr_t'(fp_q) : '0;
			res_last_q   <= alloc_ok ? addr_t'(need - 1'b1) : '0;
			res_pcb_q    <= alloc_ok ? addr_t'(pcb_sum) : '0;
			res_value_q  <= '0;
		end else if (state_q == ST_SCAN) begin
			addr_s1 <= addr_t'(addr_s1 + 1'b1);
			if (scan_hit) begin
				res_status_q <= 1'b0;
				if (op_q == OP_GET) begin
					res_value_q <= vld_q[addr_s1] ? rd_data_s1.value : '0;
				end
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			status_q     <= res_status_q;
			seg_base_q   <= res_base_q;
			seg_last_q   <= res_last_q;
			pcb_base_q   <= res_pcb_q;
			read_value_q <= res_value_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign seg_base   = seg_base_q;
	assign seg_last   = seg_last_q;
	assign pcb_base   = pcb_base_q;
	assign read_value = read_value_q;

endmodule

@@ sv/sav_checker.sv @@
module sav_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic                 status,
	input sav_pkg::addr_t       seg_base,
	input sav_pkg::addr_t       seg_last,
	input sav_pkg::addr_t       pcb_base,
	input sav_pkg::str_t        read_value
);
	import sav_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_value) && $stable(status))
		else $error("result dropped or changed while stalled");

	// Take one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while another is in progress");

	// Drop all fields on failure
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> seg_base == '0 && seg_last == '0 && pcb_base == '0
			&& read_value == '0)
		else $error("failed item carries non-zero fields");

	// Keep get and allocate fields apart
	a_get_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_value != '0 |-> seg_base == '0 && seg_last == '0
			&& pcb_base == '0)
		else $error("value and segment fields both set");

endmodule

bind segment_allocator_variable_table_core sav_checker u_sav_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.seg_base   (seg_base),
	.seg_last   (seg_last),
	.pcb_base   (pcb_base),
	.read_value (read_value)
);
